### src/bsc_pkg.sv
// Shared types, codes and constants of the stack bytecode core.
package bsc_pkg;

    localparam int PAY_W   = 64;
    localparam int TYPE_W  = 2;
    localparam int ENTRY_W = PAY_W + TYPE_W;
    localparam int IDX_W   = 8;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXEC    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [7:0] OP_PUSHC = 8'd1;
    localparam logic [7:0] OP_PUSH0 = 8'd2;
    localparam logic [7:0] OP_TRUE  = 8'd3;
    localparam logic [7:0] OP_FALSE = 8'd4;
    localparam logic [7:0] OP_ADD   = 8'd5;
    localparam logic [7:0] OP_SUB   = 8'd6;
    localparam logic [7:0] OP_MUL   = 8'd7;
    localparam logic [7:0] OP_DIV   = 8'd8;
    localparam logic [7:0] OP_JUMP  = 8'd9;
    localparam logic [7:0] OP_PRINT = 8'd12;
    localparam logic [7:0] OP_RET   = 8'd13;

    localparam logic [TYPE_W-1:0] TYPE_INT  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_BOOL = 2'd2;

    typedef enum logic [2:0] {
        STS_OK, STS_OVER, STS_UNDER, STS_DIVZ, STS_UNDEF, STS_HALT
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_PUSHC, ST_RDA, ST_ALU_GO, ST_ALU_WAIT, ST_PRINT, ST_DONE
    } t_state;

    typedef enum logic [1:0] {ALU_IDLE, ALU_DIV, ALU_FIX, ALU_DONE} t_alu_state;

    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIVIDE} t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic        divz;
        logic [31:0] result;
    } t_alu_rsp;

endpackage

### src/bsc_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module bsc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 66,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic             i_re,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= mem[i_ra];
        end
    end

endmodule

### src/bsc_alu.sv
// Shared 32-bit ALU: add, subtract, multiply and iterative signed divide.
module bsc_alu import bsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    t_alu_state  r_state, n_state;
    logic [31:0] r_res, n_res;
    logic        r_divz, n_divz;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_div, n_div;
    logic        r_neg, n_neg;

    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign mag_a  = i_req.a[31] ? -i_req.a : i_req.a;
    assign mag_b  = i_req.b[31] ? -i_req.b : i_req.b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == ALU_DIVIDE && i_req.b != 32'd0) begin
                        n_state = ALU_DIV;
                    end else begin
                        n_state = ALU_DONE;
                    end
                end
            end
            ALU_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = ALU_FIX;
                end
            end
            ALU_FIX:  n_state = ALU_DONE;
            ALU_DONE: n_state = ALU_IDLE;
            default:  n_state = ALU_IDLE;
        endcase
    end

    always_comb begin
        n_res  = r_res;
        n_divz = r_divz;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        unique case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    n_divz = 1'b0;
                    case (i_req.op)
                        ALU_ADD: n_res = i_req.a + i_req.b;
                        ALU_SUB: n_res = i_req.a - i_req.b;
                        ALU_MUL: n_res = i_req.a * i_req.b;
                        default: begin
                            n_divz = (i_req.b == 32'd0);
                            n_res  = 32'd0;
                            n_rem  = 32'd0;
                            n_quo  = mag_a;
                            n_div  = mag_b;
                            n_neg  = i_req.a[31] ^ i_req.b[31];
                            n_cnt  = 5'd0;
                        end
                    endcase
                end
            end
            ALU_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (!diff[32]) begin
                    n_rem = diff[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
            end
            ALU_FIX: n_res = r_neg ? -r_quo : r_quo;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_divz <= n_divz;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_neg  <= n_neg;
    end

    assign o_rsp.done   = (r_state == ALU_DONE);
    assign o_rsp.divz   = r_divz;
    assign o_rsp.result = r_res;

endmodule

### src/stack_bytecode_core_top.sv
// Top level of the stack bytecode core: sequencer, stack and constant pool.
// A request goes from issue to done for load, restart, jump, return, single-byte pushes,
// undefined opcodes, overflow, underflow and halted; print and push constant add a RAM read
// state; arithmetic reads both operands and waits on the ALU, dividing in 32 steps.
// Done holds while the output is stalled and goes idle as the result is registered.
// Reset empties the stack and sets the core running; RAM contents are not cleared.
module stack_bytecode_core_top import bsc_pkg::*; #(
    parameter int STACK_DEPTH = 256,
    parameter int POOL_DEPTH  = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_mode,
    input  logic [7:0]   i_opcode,
    input  logic [15:0]  i_operand,
    input  logic [1:0]   i_const_type,
    input  logic [63:0]  i_const_payload,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [16:0]  o_pc_advance,
    output logic         o_print_valid,
    output logic [1:0]   o_print_type,
    output logic [63:0]  o_print_payload,
    output logic         o_halted,
    output logic [2:0]   o_status
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    t_state             r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic               r_running, n_running;
    logic               r_ovalid;

    logic [1:0]         r_mode, n_mode;
    logic [7:0]         r_opcode, n_opcode;
    logic [15:0]        r_operand, n_operand;
    logic [1:0]         r_ctype, n_ctype;
    logic [63:0]        r_cpay, n_cpay;
    logic [31:0]        r_opb, n_opb;

    logic [16:0]        r_adv, n_adv;
    logic               r_pvalid, n_pvalid;
    logic [1:0]         r_ptype, n_ptype;
    logic [63:0]        r_ppay, n_ppay;
    t_status            r_status, n_status;

    logic               stack_we, stack_re;
    logic [SAW-1:0]     stack_wa, stack_ra;
    logic [ENTRY_W-1:0] stack_wd, stack_rd;
    logic               pool_we, pool_re;
    logic [ENTRY_W-1:0] pool_rd;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic               accept;
    logic               out_free;
    logic               exec_ok;
    logic               sp_full, sp_lt2, sp_zero;
    logic               is_arith;
    logic               idx_ok;
    logic               go_pushc, go_arith, go_print;
    logic [SPW-1:0]     sp_m1, sp_m2;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign exec_ok  = (r_mode == MODE_EXEC) && r_running;
    assign sp_full  = (r_sp == SPW'(STACK_DEPTH));
    assign sp_lt2   = (r_sp < SPW'(2));
    assign sp_zero  = (r_sp == '0);
    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);
    assign is_arith = (r_opcode >= OP_ADD) && (r_opcode <= OP_DIV);
    assign idx_ok   = {8'd0, r_operand[IDX_W-1:0]} < 16'(POOL_DEPTH);
    assign go_pushc = exec_ok && (r_opcode == OP_PUSHC) && !sp_full && idx_ok;
    assign go_arith = exec_ok && is_arith && !sp_lt2;
    assign go_print = exec_ok && (r_opcode == OP_PRINT) && !sp_zero;

    bsc_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ENTRY_W),
        .AW    (SAW)
    ) u_stack (
        .i_clk (i_clk),
        .i_we  (stack_we),
        .i_wa  (stack_wa),
        .i_wd  (stack_wd),
        .i_re  (stack_re),
        .i_ra  (stack_ra),
        .o_rd  (stack_rd)
    );

    bsc_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (ENTRY_W),
        .AW    (PAW)
    ) u_pool (
        .i_clk (i_clk),
        .i_we  (pool_we),
        .i_wa  (r_operand[PAW-1:0]),
        .i_wd  ({r_ctype, r_cpay}),
        .i_re  (pool_re),
        .i_ra  (r_operand[PAW-1:0]),
        .o_rd  (pool_rd)
    );

    bsc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (go_pushc) begin
                    n_state = ST_PUSHC;
                end else if (go_arith) begin
                    n_state = ST_RDA;
                end else if (go_print) begin
                    n_state = ST_PRINT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PUSHC:  n_state = ST_DONE;
            ST_RDA:    n_state = ST_ALU_GO;
            ST_ALU_GO: n_state = ST_ALU_WAIT;
            ST_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_PRINT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sp      = r_sp;
        n_running = r_running;
        n_mode    = r_mode;
        n_opcode  = r_opcode;
        n_operand = r_operand;
        n_ctype   = r_ctype;
        n_cpay    = r_cpay;
        n_opb     = r_opb;
        n_adv     = r_adv;
        n_pvalid  = r_pvalid;
        n_ptype   = r_ptype;
        n_ppay    = r_ppay;
        n_status  = r_status;
        stack_we  = 1'b0;
        stack_wa  = r_sp[SAW-1:0];
        stack_wd  = '0;
        stack_re  = 1'b0;
        stack_ra  = sp_m1[SAW-1:0];
        pool_we   = 1'b0;
        pool_re   = 1'b0;
        alu_req.start = 1'b0;
        alu_req.a     = stack_rd[31:0];
        alu_req.b     = r_opb;
        case (r_opcode)
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIVIDE;
        endcase
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode    = i_mode;
                    n_opcode  = i_opcode;
                    n_operand = i_operand;
                    n_ctype   = i_const_type;
                    n_cpay    = i_const_payload;
                end
            end
            ST_ISSUE: begin
                n_adv    = '0;
                n_pvalid = 1'b0;
                n_ptype  = '0;
                n_ppay   = '0;
                n_status = STS_OK;
                case (r_mode)
                    MODE_LOAD: pool_we = (r_operand < 16'(POOL_DEPTH));
                    MODE_RESTART: begin
                        n_sp      = '0;
                        n_running = 1'b1;
                    end
                    MODE_EXEC: begin
                        if (!r_running) begin
                            n_status = STS_HALT;
                        end else begin
                            n_adv = 17'd1;
                            unique case (r_opcode)
                                OP_PUSHC: begin
                                    n_adv = 17'd2;
                                    if (sp_full) begin
                                        n_status = STS_OVER;
                                    end else if (idx_ok) begin
                                        pool_re = 1'b1;
                                    end else begin
                                        stack_we = 1'b1;
                                        stack_wd = {TYPE_INT, 64'd0};
                                        n_sp     = r_sp + SPW'(1);
                                    end
                                end
                                OP_PUSH0, OP_TRUE, OP_FALSE: begin
                                    if (sp_full) begin
                                        n_status = STS_OVER;
                                    end else begin
                                        stack_we = 1'b1;
                                        n_sp     = r_sp + SPW'(1);
                                        if (r_opcode == OP_PUSH0) begin
                                            stack_wd = {TYPE_INT, 64'd0};
                                        end else if (r_opcode == OP_TRUE) begin
                                            stack_wd = {TYPE_BOOL, 64'd1};
                                        end else begin
                                            stack_wd = {TYPE_BOOL, 64'd0};
                                        end
                                    end
                                end
                                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                    if (sp_lt2) begin
                                        n_status = STS_UNDER;
                                    end else begin
                                        stack_re = 1'b1;
                                    end
                                end
                                OP_JUMP: n_adv = 17'd3 + 17'(r_operand);
                                OP_PRINT: begin
                                    if (sp_zero) begin
                                        n_status = STS_UNDER;
                                    end else begin
                                        stack_re = 1'b1;
                                        n_sp     = sp_m1;
                                    end
                                end
                                OP_RET: n_running = 1'b0;
                                default: n_status = STS_UNDEF;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            ST_PUSHC: begin
                stack_we = 1'b1;
                stack_wd = pool_rd;
                n_sp     = r_sp + SPW'(1);
            end
            ST_RDA: begin
                n_opb    = stack_rd[31:0];
                stack_re = 1'b1;
                stack_ra = sp_m2[SAW-1:0];
            end
            ST_ALU_GO: alu_req.start = 1'b1;
            ST_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    stack_we = 1'b1;
                    stack_wa = sp_m2[SAW-1:0];
                    stack_wd = {TYPE_INT, 32'd0, alu_rsp.result};
                    n_sp     = sp_m1;
                    if (alu_rsp.divz) begin
                        n_status = STS_DIVZ;
                    end
                end
            end
            ST_PRINT: begin
                n_pvalid = 1'b1;
                n_ptype  = stack_rd[ENTRY_W-1:PAY_W];
                n_ppay   = stack_rd[PAY_W-1:0];
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_running <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_running <= n_running;
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_opcode  <= n_opcode;
        r_operand <= n_operand;
        r_ctype   <= n_ctype;
        r_cpay    <= n_cpay;
        r_opb     <= n_opb;
        r_adv     <= n_adv;
        r_pvalid  <= n_pvalid;
        r_ptype   <= n_ptype;
        r_ppay    <= n_ppay;
        r_status  <= n_status;
        if (r_state == ST_DONE && out_free) begin
            o_pc_advance    <= r_adv;
            o_print_valid   <= r_pvalid;
            o_print_type    <= r_ptype;
            o_print_payload <= r_ppay;
            o_halted        <= !r_running;
            o_status        <= r_status;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stack_we && r_state != ST_ALU_WAIT) |-> !sp_full)
        else $error("push onto a full stack");

    a_alu_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALU_WAIT && alu_rsp.done) |-> !sp_lt2)
        else $error("ALU result written back with fewer than two entries");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside completion");

    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_HALT) |-> o_halted)
        else $error("halted status without halted flag");

endmodule
